// File: design/ftsm_pkg.sv
package ftsm_pkg;

  // field widths
  localparam int unsigned CP_W     = 21;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned QCHARS   = 32;
  localparam int unsigned QLEN_W   = 5;
  localparam int unsigned QWORD_W  = 64;

  // title length default
  localparam int unsigned TITLE_LEN_DEF = 32;

  // configuration port
  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  // register indexes (byte address is 8 times the index)
  typedef enum logic [2:0] {
    REG_QLEN    = 3'd0,
    REG_QCHAR_A = 3'd1,
    REG_QCHAR_B = 3'd2,
    REG_QCHAR_C = 3'd3,
    REG_QCHAR_D = 3'd4
  } reg_idx_e;

  // query settings handed to the matcher
  typedef struct packed {
    logic [QLEN_W-1:0]               len;
    logic [QCHARS-1:0][CHAR_W-1:0]   chars;
  } query_cfg_t;

  // character codes
  localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CASE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h63;
  localparam logic [CHAR_W-1:0] CH_E    = 8'h65;
  localparam logic [CHAR_W-1:0] CH_I    = 8'h69;
  localparam logic [CHAR_W-1:0] CH_N    = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_O    = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_U    = 8'h75;
  localparam logic [CHAR_W-1:0] CH_Y    = 8'h79;

  // lower A to Z, leave everything else
  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] r;
    r = b;
    if (b >= CH_UP_A && b <= CH_UP_Z) r = b + CH_CASE;
    return r;
  endfunction

  // fold a code point to ascii, A to Z lowered, zero means dropped
  function automatic logic [CHAR_W-1:0] fold_point(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0]   p;
    logic [CHAR_W-1:0] c;
    p = cp;
    c = '0;
    if (cp < 21'h80) begin
      c = cp[CHAR_W-1:0];
    end else begin
      // latin-1 uppercase to lowercase, multiplication sign excluded
      if (p >= 21'hC0 && p <= 21'hDE && p != 21'hD7) p = p + 21'h20;
      if (p >= 21'hE0 && p <= 21'hE5)      c = CH_A;
      else if (p == 21'hE7)                c = CH_C;
      else if (p >= 21'hE8 && p <= 21'hEB) c = CH_E;
      else if (p >= 21'hEC && p <= 21'hEF) c = CH_I;
      else if (p == 21'hF1)                c = CH_N;
      else if (p >= 21'hF2 && p <= 21'hF6) c = CH_O;
      else if (p >= 21'hF9 && p <= 21'hFC) c = CH_U;
      else if (p == 21'hFD || p == 21'hFF) c = CH_Y;
      else                                 c = '0;
    end
    return lower_ascii(c);
  endfunction

endpackage

// File: design/ftsm_ifs.sv
interface ftsm_title_if;
  import ftsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic              end_of_title;

  modport source (output valid, output code_point, output end_of_title, input ready);
  modport sink   (input valid, input code_point, input end_of_title, output ready);
endinterface

interface ftsm_result_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

// File: design/folded_title_substring_match_core.sv
// channel   | dir | payload                   | handshake
// title_i   | in  | code_point, end_of_title  | valid / ready
// result_o  | out | matched                   | valid / ready
// apb       | in  | query registers           | psel / penable, pready tied high
//
// one code point per cycle sustained, unless an end of title waits behind a held
// result; a request is held in the input register, then the fold and shift-and
// lanes update the title state; a result is loaded into the result register at
// the same edge its last code point leaves the input register
// only the result register can stall the pipe
// reset is asynchronous and clears all title state and query registers at once
module folded_title_substring_match_core #(
  parameter int unsigned TITLE_LEN = ftsm_pkg::TITLE_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ftsm_title_if.sink                    title_i,
  ftsm_result_if.source                 result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftsm_pkg::APB_AW-1:0]   paddr,
  input  logic [ftsm_pkg::APB_DW-1:0]   pwdata,
  output logic [ftsm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ftsm_pkg::*;

  query_cfg_t       cfg;
  logic             s1_valid_q, s1_eot_q;
  logic [CP_W-1:0]  s1_cp_q;
  logic             s1_adv, res_free, in_take;
  logic             res_valid_q, res_matched_q, matched;

  // configuration registers
  ftsm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake control
  assign res_free      = !res_valid_q || result_o.ready;
  assign s1_adv        = s1_valid_q && (!s1_eot_q || res_free);
  assign title_i.ready = !s1_valid_q || s1_adv;
  assign in_take       = title_i.valid && title_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (title_i.ready) begin
      s1_valid_q <= title_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cp_q  <= title_i.code_point;
      s1_eot_q <= title_i.end_of_title;
    end
  end

  // fold and match
  ftsm_matcher #(
    .TITLE_LEN (TITLE_LEN)
  ) u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s1_adv),
    .code_point_i   (s1_cp_q),
    .end_of_title_i (s1_eot_q),
    .cfg_i          (cfg),
    .matched_o      (matched)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && s1_eot_q) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_eot_q) res_matched_q <= matched;
  end

  assign result_o.valid   = res_valid_q;
  assign result_o.matched = res_matched_q;

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !title_i.ready |-> (s1_valid_q && s1_eot_q && res_valid_q && !result_o.ready))
    else $error("input stalled without a blocked result");

  // a new result comes only from a finished title
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_adv && s1_eot_q))
    else $error("result without end of title");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !result_o.ready && s1_valid_q && s1_eot_q |-> !s1_adv)
    else $error("result overwritten while stalled");

endmodule

// File: design/ftsm_apb_regs.sv
module ftsm_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftsm_pkg::APB_AW-1:0]   paddr,
  input  logic [ftsm_pkg::APB_DW-1:0]   pwdata,
  output logic [ftsm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output ftsm_pkg::query_cfg_t          cfg_o
);
  import ftsm_pkg::*;

  logic [QLEN_W-1:0]  qlen_q;
  logic [QWORD_W-1:0] qa_q, qb_q, qc_q, qd_q;
  logic               wr_en;
  logic [2:0]         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q <= '0;
      qa_q   <= '0;
      qb_q   <= '0;
      qc_q   <= '0;
      qd_q   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_QLEN:    qlen_q <= pwdata[QLEN_W-1:0];
        REG_QCHAR_A: qa_q   <= pwdata;
        REG_QCHAR_B: qb_q   <= pwdata;
        REG_QCHAR_C: qc_q   <= pwdata;
        REG_QCHAR_D: qd_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_QLEN:    prdata = {{(APB_DW-QLEN_W){1'b0}}, qlen_q};
      REG_QCHAR_A: prdata = qa_q;
      REG_QCHAR_B: prdata = qb_q;
      REG_QCHAR_C: prdata = qc_q;
      REG_QCHAR_D: prdata = qd_q;
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.len   = qlen_q;
  assign cfg_o.chars = {qd_q, qc_q, qb_q, qa_q};

endmodule

// File: design/ftsm_matcher.sv
module ftsm_matcher #(
  parameter int unsigned TITLE_LEN = ftsm_pkg::TITLE_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [ftsm_pkg::CP_W-1:0]   code_point_i,
  input  logic                        end_of_title_i,
  input  ftsm_pkg::query_cfg_t        cfg_i,
  output logic                        matched_o
);
  import ftsm_pkg::*;

  localparam int unsigned PM_W = TITLE_LEN - 1;
  localparam int unsigned KW   = (TITLE_LEN > 2) ? $clog2(TITLE_LEN) : 1;

  logic [PM_W-1:0]   pm_q, pm_d, mask, sel;
  logic [KW-1:0]     kept_q, kept_d;
  logic              found_q, found_d, found_upd;
  logic              ended_q, ended_d;
  logic [QLEN_W-1:0] qlen;
  logic [CHAR_W-1:0] ch;
  logic              keep;

  // query length clipped to the title window
  assign qlen = (cfg_i.len > QLEN_W'(PM_W)) ? QLEN_W'(PM_W) : cfg_i.len;
  assign ch   = fold_point(code_point_i);

  // one compare lane per query character
  always_comb begin
    for (int i = 0; i < PM_W; i++) begin
      mask[i] = (QLEN_W'(i) < qlen) && (lower_ascii(cfg_i.chars[i]) == ch);
      sel[i]  = (qlen == QLEN_W'(i + 1));
    end
  end

  assign keep = !ended_q && (code_point_i != '0) && (ch != '0)
                && (kept_q < KW'(PM_W));

  // shift-and update
  always_comb begin
    pm_d      = pm_q;
    kept_d    = kept_q;
    ended_d   = ended_q;
    found_upd = found_q;
    if (!ended_q && code_point_i == '0) begin
      ended_d = 1'b1;
    end else if (keep) begin
      pm_d      = PM_W'({pm_q, 1'b1}) & mask;
      found_upd = found_q || (|(pm_d & sel));
      kept_d    = kept_q + KW'(1);
    end
    found_d = found_upd;
    // title done, start over
    if (end_of_title_i) begin
      pm_d    = '0;
      kept_d  = '0;
      found_d = 1'b0;
      ended_d = 1'b0;
    end
  end

  assign matched_o = found_upd || (qlen == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q    <= '0;
      kept_q  <= '0;
      found_q <= 1'b0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      pm_q    <= pm_d;
      kept_q  <= kept_d;
      found_q <= found_d;
      ended_q <= ended_d;
    end
  end

  // kept count stays inside the title window
  a_kept_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KW'(PM_W))
    else $error("kept count beyond title window");

  // end of title clears all title state
  a_title_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && end_of_title_i |=> (pm_q == '0 && kept_q == '0 && !found_q && !ended_q))
    else $error("title state not cleared");

  // a partial match needs a kept character
  a_pm_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pm_q != '0) |-> (kept_q != '0))
    else $error("partial match with no kept character");

endmodule

// File: bench/tb_folded_title_substring_match_core.sv
`timescale 1ns / 1ps

module tb_folded_title_substring_match_core;
  import ftsm_pkg::*;

  localparam int unsigned TITLE_MAX   = TITLE_LEN_DEF;
  localparam int unsigned KEEP_MAX    = TITLE_MAX - 1;
  localparam int unsigned ITEM_GOAL   = 950;
  localparam int unsigned DRAIN_CYC   = 4;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 300;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ftsm_title_if  title_if ();
  ftsm_result_if result_if ();

  folded_title_substring_match_core #(
    .TITLE_LEN (TITLE_MAX)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .title_i  (title_if.sink),
    .result_o (result_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // query registers as the block should hold them
  logic [QLEN_W-1:0]  q_len;
  logic [QWORD_W-1:0] q_words [4];

  // title scan state of the matcher
  logic [KEEP_MAX-1:0] partial_vec;
  int unsigned         kept_cnt;
  logic                title_found;
  logic                title_stopped;

  // expected match flags, oldest first
  logic match_q [$];

  logic [CP_W-1:0] title_buf [$];
  int unsigned     err_cnt;
  int unsigned     sent_cnt;
  int unsigned     burst_left;
  bit              gaps_on;
  int unsigned     hold_req_cnt;
  int unsigned     idle_cyc;
  logic            want_match;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'h20 : b;
  endfunction

  // code point to folded byte with A to Z lowered, zero when dropped
  function automatic logic [7:0] fold_code(input logic [CP_W-1:0] cp);
    logic [7:0] b;
    logic [7:0] c;
    c = 8'h00;
    if (cp < 'h80) begin
      c = cp[7:0];
    end else if (cp <= 'hFF) begin
      b = cp[7:0];
      if (b >= 8'hC0 && b <= 8'hDE && b != 8'hD7) b = b + 8'h20;
      if (b >= 8'hE0 && b <= 8'hE5)      c = "a";
      else if (b == 8'hE7)               c = "c";
      else if (b >= 8'hE8 && b <= 8'hEB) c = "e";
      else if (b >= 8'hEC && b <= 8'hEF) c = "i";
      else if (b == 8'hF1)               c = "n";
      else if (b >= 8'hF2 && b <= 8'hF6) c = "o";
      else if (b >= 8'hF9 && b <= 8'hFC) c = "u";
      else if (b == 8'hFD || b == 8'hFF) c = "y";
    end
    return to_lower(c);
  endfunction

  function automatic logic [7:0] query_byte(input int unsigned i);
    return to_lower(q_words[i / 8][(i % 8) * 8 +: 8]);
  endfunction

  function automatic int unsigned used_len();
    return (q_len > KEEP_MAX) ? KEEP_MAX : q_len;
  endfunction

  function automatic void clear_title_state();
    partial_vec   = '0;
    kept_cnt      = 0;
    title_found   = 1'b0;
    title_stopped = 1'b0;
  endfunction

  // shift-and step for one accepted request
  function automatic void scan_code(input logic [CP_W-1:0] cp, input logic eot);
    logic [KEEP_MAX-1:0] mask;
    logic [7:0]          c;
    int unsigned         n;
    n = used_len();
    if (!title_stopped) begin
      if (cp == '0) begin
        title_stopped = 1'b1;
      end else begin
        c = fold_code(cp);
        if (c != 8'h00 && kept_cnt < KEEP_MAX) begin
          mask = '0;
          for (int i = 0; i < n; i++) begin
            if (query_byte(i) == c) mask[i] = 1'b1;
          end
          partial_vec = {partial_vec[KEEP_MAX-2:0], 1'b1} & mask;
          if (n > 0 && partial_vec[n-1]) title_found = 1'b1;
          kept_cnt++;
        end
      end
    end
    if (eot) begin
      match_q.push_back(title_found || n == 0);
      clear_title_state();
    end
  endfunction

  // predict on accepted requests, then compare accepted results
  always @(posedge clk_i) begin
    if (rst_ni && title_if.valid && title_if.ready) begin
      scan_code(title_if.code_point, title_if.end_of_title);
    end
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (match_q.size() == 0) begin
        $display("%0t: unexpected result, matched %0b", $time, result_if.matched);
        err_cnt++;
      end else begin
        want_match = match_q.pop_front();
        if (result_if.matched !== want_match) begin
          $display("%0t: matched expected %0b actual %0b", $time, want_match,
                   result_if.matched);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk_i) begin
    if ((title_if.valid && title_if.ready) || (result_if.valid && result_if.ready) || psel) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side stall pattern, with long hold-offs on request
  initial begin : rx_stall
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_seen;
    int unsigned hold_left;
    mode      = 0;
    mode_left = 0;
    hold_seen = 0;
    hold_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = LONG_HOLD - 1;
        result_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: result_if.ready <= 1'b1;
          1: result_if.ready <= $urandom_range(0, 1);
          default: result_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // one title request, then maybe a gap between bursts
  task automatic push_code(input logic [CP_W-1:0] cp, input logic eot);
    title_if.valid        <= 1'b1;
    title_if.code_point   <= cp;
    title_if.end_of_title <= eot;
    @(posedge clk_i);
    while (!title_if.ready) @(posedge clk_i);
    sent_cnt++;
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
        title_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_title();
    for (int i = 0; i < title_buf.size(); i++) begin
      push_code(title_buf[i], i == title_buf.size() - 1);
    end
  endtask

  // stop offering and let the block drain completely
  task automatic wait_idle();
    title_if.valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write then read back
  task automatic cfg_write(input reg_idx_e idx, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] want;
    want    = (idx == REG_QLEN) ? (data & 64'h1F) : data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 3'b000});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_QLEN:    q_len      = data[QLEN_W-1:0];
      REG_QCHAR_A: q_words[0] = data;
      REG_QCHAR_B: q_words[1] = data;
      REG_QCHAR_C: q_words[2] = data;
      REG_QCHAR_D: q_words[3] = data;
      default: ;
    endcase
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %s read expected %h actual %h", $time, idx.name(), want,
               prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_query(input logic [QLEN_W-1:0] len, input logic [QWORD_W-1:0] wa,
                            input logic [QWORD_W-1:0] wb, input logic [QWORD_W-1:0] wc,
                            input logic [QWORD_W-1:0] wd);
    cfg_write(REG_QCHAR_A, wa);
    cfg_write(REG_QCHAR_B, wb);
    cfg_write(REG_QCHAR_C, wc);
    cfg_write(REG_QCHAR_D, wd);
    cfg_write(REG_QLEN, 64'(len));
  endtask

  task automatic load_query_text(input string s);
    logic [QWORD_W-1:0] w [4];
    for (int i = 0; i < 4; i++) w[i] = '0;
    for (int i = 0; i < s.len(); i++) w[i / 8][(i % 8) * 8 +: 8] = s[i];
    load_query(QLEN_W'(s.len()), w[0], w[1], w[2], w[3]);
  endtask

  // some code point that folds to the given letter
  function automatic logic [CP_W-1:0] encode_char(input logic [7:0] b);
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] cand;
    int unsigned     tries;
    cp = CP_W'(b);
    case ($urandom_range(0, 3))
      0: if (b >= "a" && b <= "z") cp = CP_W'(b - 8'h20);
      1: begin
        tries = 0;
        while (tries < 48) begin
          cand = CP_W'($urandom_range('hC0, 'hFF));
          if (fold_code(cand) == b) begin
            cp    = cand;
            tries = 48;
          end
          tries++;
        end
      end
      default: ;
    endcase
    return cp;
  endfunction

  function automatic logic [CP_W-1:0] noise_code();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return encode_char(8'("a" + $urandom_range(0, 3)));
      5: return CP_W'($urandom_range(1, 'h7F));
      6: return CP_W'($urandom_range('h80, 'hFF));
      7: return CP_W'($urandom_range('h100, 'h10FFFF));
      8: return CP_W'($urandom_range('h110000, 'h1FFFFF));
      default: return r[CP_W-1:0];
    endcase
  endfunction

  // title around the current query, with noise and broken copies
  task automatic build_title();
    int unsigned n;
    int unsigned pre;
    int unsigned pos;
    n = used_len();
    title_buf.delete();
    pre = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 35) : $urandom_range(0, 6);
    repeat (pre) title_buf.push_back(noise_code());
    if ($urandom_range(0, 2) != 0) begin
      for (int i = 0; i < n; i++) title_buf.push_back(encode_char(query_byte(i)));
      if (n > 0 && $urandom_range(0, 4) == 0) begin
        pos = title_buf.size() - 1 - $urandom_range(0, n - 1);
        title_buf[pos] = noise_code();
      end
    end
    repeat ($urandom_range(0, 4)) title_buf.push_back(noise_code());
    if (title_buf.size() == 0) title_buf.push_back(noise_code());
    if ($urandom_range(0, 14) == 0) begin
      title_buf[$urandom_range(0, title_buf.size() - 1)] = '0;
    end
  endtask

  // empty query after reset matches anything
  task automatic test_empty_query();
    push_code(CP_W'("Q"), 1'b1);
    push_code(CP_W'('h100), 1'b1);
    wait_idle();
  endtask

  // case and accent folding, dropped code points in between
  task automatic test_folding();
    load_query_text("cAFe");
    title_buf = '{CP_W'("C"), CP_W'('hC1), CP_W'('hD7), CP_W'('h1FFFFF), CP_W'("F"),
                  CP_W'('hC9)};
    send_title();
    title_buf = '{CP_W'('hE7), CP_W'('hE0), CP_W'("f"), CP_W'('hFF)};
    send_title();
    wait_idle();
  endtask

  // zero code point ends the title text
  task automatic test_stopped_title();
    load_query_text("ab");
    title_buf = '{CP_W'("a"), CP_W'(0), CP_W'("b")};
    send_title();
    wait_idle();
  endtask

  // query bytes that no folded character can equal
  task automatic test_bad_query_bytes();
    load_query(QLEN_W'(2), 64'h61C1, '0, '0, '0);
    title_buf = '{CP_W'('hC1), CP_W'("a")};
    send_title();
    wait_idle();
    load_query(QLEN_W'(2), 64'h6100, '0, '0, '0);
    title_buf = '{CP_W'('hE1), CP_W'("a")};
    send_title();
    wait_idle();
  endtask

  // partial match survives a query change inside a title
  task automatic test_query_change_mid_title();
    load_query_text("ab");
    push_code(CP_W'("a"), 1'b0);
    wait_idle();
    load_query_text("xb");
    push_code(CP_W'("b"), 1'b1);
    wait_idle();
  endtask

  // long receiver hold while one-request titles keep coming
  task automatic test_back_pressure();
    gaps_on = 1'b0;
    load_query_text("b");
    hold_req_cnt++;
    repeat (60) push_code(encode_char(8'("a" + $urandom_range(0, 3))), 1'b1);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // random queries and titles, extremes first
  task automatic test_random_titles();
    int unsigned        phase_idx;
    logic [QWORD_W-1:0] w [4];
    logic [QLEN_W-1:0]  len;
    bit                 raw_bytes;
    phase_idx = 0;
    while (sent_cnt < ITEM_GOAL) begin
      raw_bytes = ($urandom_range(0, 4) == 0);
      case (phase_idx)
        0: len = '0;
        1, 2: len = QLEN_W'(31);
        3: len = QLEN_W'(1);
        default: len = ($urandom_range(0, 3) == 0) ? QLEN_W'($urandom_range(0, 31))
                                                   : QLEN_W'($urandom_range(1, 6));
      endcase
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 8; j++) begin
          w[k][j * 8 +: 8] = 8'("a" + $urandom_range(0, 3));
          if ($urandom_range(0, 1) == 0) w[k][j * 8 +: 8] = w[k][j * 8 +: 8] - 8'h20;
        end
        if (raw_bytes) w[k] = {$urandom, $urandom};
        if (phase_idx == 0) w[k] = '0;
        if (phase_idx == 1) w[k] = '1;
      end
      load_query(len, w[0], w[1], w[2], w[3]);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(6, 14)) begin
        if (sent_cnt < ITEM_GOAL) begin
          build_title();
          send_title();
        end
      end
      wait_idle();
      phase_idx++;
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    title_if.valid        = 1'b0;
    title_if.code_point   = '0;
    title_if.end_of_title = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    q_len                 = '0;
    for (int k = 0; k < 4; k++) q_words[k] = '0;
    clear_title_state();
    err_cnt      = 0;
    sent_cnt     = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    hold_req_cnt = 0;
    idle_cyc     = 0;

    // reset
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_query();
    test_folding();
    test_stopped_title();
    test_bad_query_bytes();
    test_query_change_mid_title();
    test_back_pressure();
    test_random_titles();

    // final drain
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
